/* hdl/stq_pkg.sv */
package stq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int IDX_W       = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int TIME_W      = 63;
    localparam int IVL_W       = 40;
    localparam int SEQ_W       = 32;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_EXPIRE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_ADDED     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_MISSED    = 3'd3,
        KIND_EXPIRED   = 3'd4,
        KIND_DONE      = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        SCAN_ALL   = 2'd0,
        SCAN_FINAL = 2'd1,
        SCAN_PICK  = 2'd2
    } t_scan;

    typedef struct packed {
        logic  load;
        logic  scan_clr;
        logic  scan_step;
        t_scan mode;
        logic  cancel_chk;
        logic  emit_add;
        logic  emit_cancel;
        logic  fire;
        logic  emit_done;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic scan_last;
        logic due_any;
    } t_dp_sts;

endpackage

/* hdl/stq_ctrl.sv */
module stq_ctrl import stq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    busy_unused_n,
    input  t_cmd    i_command,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_CAN_CHK  = 9'b000000010,
        ST_SCAN_MIN = 9'b000000100,
        ST_EXP_NEXT = 9'b000001000,
        ST_EXP_PICK = 9'b000010000,
        ST_EXP_FIRE = 9'b000100000,
        ST_ADD_EMIT = 9'b001000000,
        ST_CAN_EMIT = 9'b010000000,
        ST_DONE     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mode = SCAN_ALL;
        case (r_state)
            ST_IDLE: begin
                if (start && busy_unused_n) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_command == CMD_CANCEL) ? ST_CAN_CHK : ST_SCAN_MIN;
                end
            end
            ST_CAN_CHK: begin
                o_cmd.cancel_chk = 1'b1;
                n_state = ST_SCAN_MIN;
            end
            ST_SCAN_MIN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.mode = (i_sts.cmd == CMD_EXPIRE) ? SCAN_FINAL : SCAN_ALL;
                if (i_sts.scan_last) begin
                    case (i_sts.cmd)
                        CMD_ADD:    n_state = ST_ADD_EMIT;
                        CMD_CANCEL: n_state = ST_CAN_EMIT;
                        CMD_EXPIRE: n_state = ST_EXP_NEXT;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_EXP_NEXT: begin
                // due timers are fired one per pick pass, earliest first
                if (i_sts.due_any) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state = ST_EXP_PICK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_EXP_PICK: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.mode = SCAN_PICK;
                if (i_sts.scan_last) begin
                    n_state = ST_EXP_FIRE;
                end
            end
            ST_EXP_FIRE: begin
                o_cmd.fire = 1'b1;
                n_state = ST_EXP_NEXT;
            end
            ST_ADD_EMIT: begin
                o_cmd.emit_add = 1'b1;
                n_state = ST_IDLE;
            end
            ST_CAN_EMIT: begin
                o_cmd.emit_cancel = 1'b1;
                n_state = ST_IDLE;
            end
            ST_DONE: begin
                o_cmd.emit_done = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

/* hdl/stq_dp.sv */
module stq_dp import stq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  t_cmd                i_command,
    input  logic [TIME_W-1:0]   i_expire_at,
    input  logic [IVL_W-1:0]    i_interval_us,
    input  logic [3:0]          i_slot,
    input  logic [SEQ_W-1:0]    i_sequence_req,
    input  logic [TIME_W-1:0]   i_now,
    output t_dp_sts             o_sts,
    output logic                o_valid,
    output logic [2:0]          o_kind,
    output logic [3:0]          o_timer_slot,
    output logic [SEQ_W-1:0]    o_timer_sequence,
    output logic                o_became_first,
    output logic                o_next_valid,
    output logic [TIME_W-1:0]   o_next_deadline,
    output logic                o_last
);

    // slot file
    logic [TIMER_SLOTS-1:0] r_valid;
    logic [TIMER_SLOTS-1:0] r_due;
    logic [TIME_W-1:0]      r_exp [TIMER_SLOTS];
    logic [IVL_W-1:0]       r_ivl [TIMER_SLOTS];
    logic [SEQ_W-1:0]       r_seq [TIMER_SLOTS];
    logic [SEQ_W-1:0]       r_seqcnt;

    // latched transaction
    t_cmd                   r_cmd;
    logic [TIME_W-1:0]      r_at;
    logic [IVL_W-1:0]       r_ivl_in;
    logic [3:0]             r_slot;
    logic [SEQ_W-1:0]       r_sreq;
    logic [TIME_W-1:0]      r_now;

    // scan state
    logic [IDX_W-1:0]       r_idx;
    logic                   r_min_any;
    logic [TIME_W-1:0]      r_min;
    logic                   r_free_any;
    logic [IDX_W-1:0]       r_free_idx;
    logic                   r_pk_any;
    logic [IDX_W-1:0]       r_pk_idx;
    logic [TIME_W-1:0]      r_pk_exp;
    logic [TIME_W-1:0]      r_pk_new;
    logic                   r_pk_rep;
    logic [SEQ_W-1:0]       r_pk_seq;
    logic                   r_hit;

    logic [TIME_W-1:0]      rd_exp;
    logic [IVL_W-1:0]       rd_ivl;
    logic [SEQ_W-1:0]       rd_seq;
    logic                   rd_valid;
    logic                   due_now;
    logic [TIME_W:0]        sum;
    logic [TIME_W-1:0]      rearm;
    logic                   cand_ok;
    logic [TIME_W-1:0]      cand_val;
    logic                   min_upd;
    logic                   pk_upd;
    logic                   hit;
    logic [SEQ_W-1:0]       seq_new;
    logic                   at_first;

    assign rd_exp   = r_exp[r_idx];
    assign rd_ivl   = r_ivl[r_idx];
    assign rd_seq   = r_seq[r_idx];
    assign rd_valid = r_valid[r_idx];
    assign due_now  = rd_valid && (rd_exp <= r_now);
    assign sum      = {1'b0, r_now} + (TIME_W+1)'(rd_ivl);
    assign rearm    = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    always_comb begin
        cand_ok  = rd_valid;
        cand_val = rd_exp;
        case (i_cmd.mode)
            SCAN_ALL: begin
                cand_ok  = rd_valid;
                cand_val = rd_exp;
            end
            SCAN_FINAL: begin
                // state after the expire: due one-shots gone, repeaters re-armed
                cand_ok  = rd_valid && (!due_now || (rd_ivl != '0));
                cand_val = due_now ? rearm : rd_exp;
            end
            SCAN_PICK: begin
                cand_ok  = r_due[r_idx];
                cand_val = rd_exp;
            end
            default: begin
                cand_ok  = 1'b0;
                cand_val = rd_exp;
            end
        endcase
    end

    assign min_upd = i_cmd.scan_step && (i_cmd.mode != SCAN_PICK) && cand_ok &&
                     (!r_min_any || (cand_val < r_min));
    assign pk_upd  = i_cmd.scan_step && (i_cmd.mode == SCAN_PICK) && cand_ok &&
                     (!r_pk_any || (cand_val < r_pk_exp));
    assign hit     = (32'(r_slot) < 32'(TIMER_SLOTS)) && rd_valid && (rd_seq == r_sreq);
    assign seq_new = r_seqcnt + SEQ_W'(1);
    assign at_first = !r_min_any || (r_at < r_min);

    assign o_sts.cmd       = r_cmd;
    assign o_sts.scan_last = (r_idx == IDX_W'(TIMER_SLOTS - 1));
    assign o_sts.due_any   = |r_due;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_due    <= '0;
            r_seqcnt <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_add || i_cmd.emit_cancel || i_cmd.fire || i_cmd.emit_done;
            if (i_cmd.load) begin
                r_due <= '0;
            end
            if (i_cmd.scan_step && (i_cmd.mode == SCAN_FINAL)) begin
                r_due[r_idx] <= due_now;
            end
            if (i_cmd.cancel_chk && hit) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (i_cmd.emit_add && r_free_any) begin
                r_valid[r_free_idx] <= 1'b1;
                r_seqcnt            <= seq_new;
            end
            if (i_cmd.fire) begin
                r_due[r_pk_idx] <= 1'b0;
                if (!r_pk_rep) begin
                    r_valid[r_pk_idx] <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_command;
            r_at       <= i_expire_at;
            r_ivl_in   <= i_interval_us;
            r_slot     <= i_slot;
            r_sreq     <= i_sequence_req;
            r_now      <= i_now;
            r_idx      <= (i_command == CMD_CANCEL) ? IDX_W'(i_slot) : '0;
            r_min_any  <= 1'b0;
            r_min      <= '0;
            r_free_any <= 1'b0;
            r_free_idx <= '0;
        end
        if (i_cmd.cancel_chk) begin
            r_hit <= hit;
            r_idx <= '0;
        end
        if (i_cmd.scan_clr) begin
            r_idx    <= '0;
            r_pk_any <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= IDX_W'(r_idx + IDX_W'(1));
            if (min_upd) begin
                r_min_any <= 1'b1;
                r_min     <= cand_val;
            end
            if ((i_cmd.mode == SCAN_ALL) && !rd_valid && !r_free_any) begin
                r_free_any <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (pk_upd) begin
                r_pk_any <= 1'b1;
                r_pk_idx <= r_idx;
                r_pk_exp <= rd_exp;
                r_pk_new <= rearm;
                r_pk_rep <= (rd_ivl != '0);
                r_pk_seq <= rd_seq;
            end
        end
        if (i_cmd.emit_add && r_free_any) begin
            r_exp[r_free_idx] <= r_at;
            r_ivl[r_free_idx] <= r_ivl_in;
            r_seq[r_free_idx] <= seq_new;
        end
        if (i_cmd.fire && r_pk_rep) begin
            r_exp[r_pk_idx] <= r_pk_new;
        end

        // result register
        o_became_first   <= 1'b0;
        o_next_valid     <= r_min_any;
        o_next_deadline  <= r_min;
        o_last           <= 1'b1;
        o_kind           <= KIND_DONE;
        o_timer_slot     <= '0;
        o_timer_sequence <= '0;
        if (i_cmd.emit_add) begin
            if (r_free_any) begin
                o_kind           <= KIND_ADDED;
                o_timer_slot     <= 4'(r_free_idx);
                o_timer_sequence <= seq_new;
                o_became_first   <= at_first;
                o_next_valid     <= 1'b1;
                o_next_deadline  <= at_first ? r_at : r_min;
            end else begin
                o_kind <= KIND_FULL;
            end
        end else if (i_cmd.emit_cancel) begin
            o_kind           <= r_hit ? KIND_CANCELLED : KIND_MISSED;
            o_timer_slot     <= r_slot;
            o_timer_sequence <= r_sreq;
        end else if (i_cmd.fire) begin
            o_kind           <= KIND_EXPIRED;
            o_timer_slot     <= 4'(r_pk_idx);
            o_timer_sequence <= r_pk_seq;
            o_last           <= 1'b0;
        end
    end

    a_fire_has_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire |-> (r_pk_any && r_due[r_pk_idx]))
        else $error("fire without a due timer picked");

    a_load_clears_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_due == '0))
        else $error("due set not cleared on new transaction");

    a_not_last_is_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_kind == KIND_EXPIRED))
        else $error("non-final result that is not an expiry");

    a_due_subset_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_due & ~r_valid) == '0))
        else $error("due timer in a free slot");

endmodule

/* hdl/sorted_timer_queue_unit.sv */
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// input     | start, busy          | i_command, i_expire_at, i_interval_us,
//           |                      | i_slot, i_sequence_req, i_now
// result    | o_valid (one cycle)  | o_kind, o_timer_slot, o_timer_sequence,
//           |                      | o_became_first, o_next_valid,
//           |                      | o_next_deadline, o_last
//
// add and unused commands make one scan of all TIMER_SLOTS slots; cancel first
// checks the named slot, then scans. expire scans once; then each due timer costs
// one full pass of the single slot-file read port to find the earliest.
// synchronous active-low reset frees all slots and zeroes the sequence counter.
// a result is valid for one cycle only; the receiver cannot stall.
module sorted_timer_queue_unit import stq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_command,
    input  logic [TIME_W-1:0]   i_expire_at,
    input  logic [IVL_W-1:0]    i_interval_us,
    input  logic [3:0]          i_slot,
    input  logic [SEQ_W-1:0]    i_sequence_req,
    input  logic [TIME_W-1:0]   i_now,
    output logic                o_valid,
    output logic [2:0]          o_kind,
    output logic [3:0]          o_timer_slot,
    output logic [SEQ_W-1:0]    o_timer_sequence,
    output logic                o_became_first,
    output logic                o_next_valid,
    output logic [TIME_W-1:0]   o_next_deadline,
    output logic                o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_cmd    command;

    assign command = t_cmd'(i_command);

    stq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy_unused_n (!busy),
        .i_command     (command),
        .i_sts         (dp_sts),
        .o_cmd         (dp_cmd),
        .busy          (busy)
    );

    stq_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .i_command          (command),
        .i_expire_at        (i_expire_at),
        .i_interval_us      (i_interval_us),
        .i_slot             (i_slot),
        .i_sequence_req     (i_sequence_req),
        .i_now              (i_now),
        .o_sts              (dp_sts),
        .o_valid            (o_valid),
        .o_kind             (o_kind),
        .o_timer_slot       (o_timer_slot),
        .o_timer_sequence   (o_timer_sequence),
        .o_became_first     (o_became_first),
        .o_next_valid       (o_next_valid),
        .o_next_deadline    (o_next_deadline),
        .o_last             (o_last)
    );

endmodule
